// ----- sv/teach_and_replay_point_sequencer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the teach-and-replay point sequencer
// Shared implication and next-cycle property forms, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TEACH_AND_REPLAY_POINT_SEQUENCER_UNIT_ASSERT_SVH
`define TEACH_AND_REPLAY_POINT_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication
`define TARPS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TARPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tarps_pkg.sv -----
// ----------------------------------------------------------------------------
// tarps_pkg
// Types, register indexes, reset defaults and small per-axis helpers for the
// teach-and-replay point sequencer.
// ----------------------------------------------------------------------------
package tarps_pkg;

  // Three 8-bit angles, axis 0 in the lowest byte
  typedef logic [2:0][7:0] angles_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_MIN_ANGLE     = 3'd0;
  localparam logic [2:0] CFG_MAX_ANGLE     = 3'd1;
  localparam logic [2:0] CFG_HOME_ANGLE_0  = 3'd2;
  localparam logic [2:0] CFG_HOME_ANGLE_1  = 3'd3;
  localparam logic [2:0] CFG_HOME_ANGLE_2  = 3'd4;
  localparam logic [2:0] CFG_INITIAL_SPEED = 3'd5;
  localparam logic [2:0] CFG_SPEED_STEP    = 3'd6;

  // Register reset values
  localparam logic [7:0] RST_MIN_ANGLE     = 8'd50;
  localparam logic [7:0] RST_MAX_ANGLE     = 8'd190;
  localparam logic [7:0] RST_HOME_ANGLE_0  = 8'd90;
  localparam logic [7:0] RST_HOME_ANGLE_1  = 8'd120;
  localparam logic [7:0] RST_HOME_ANGLE_2  = 8'd150;
  localparam logic [7:0] RST_INITIAL_SPEED = 8'd20;
  localparam logic [5:0] RST_SPEED_STEP    = 6'd5;

  // Upper limit of a speed raise
  localparam logic [8:0] SPEED_CEIL = 9'd250;

  // Status codes
  localparam logic [1:0] MODE_TEACH  = 2'd0;
  localparam logic [1:0] MODE_REPLAY = 2'd1;
  localparam logic [1:0] MODE_IDLE   = 2'd2;

  // Fixed field widths of the result beat
  localparam int unsigned PIDX_W = 6;
  localparam int unsigned PCNT_W = 7;

  // One jog of one axis: up first, then down, each within the limits
  function automatic logic [7:0] jog_axis(logic [7:0] a, logic up, logic dn,
                                          logic [7:0] lo, logic [7:0] hi);
    logic [7:0] r;
    r = a;
    if (up && r < hi) r = r + 8'd1;
    if (dn && r > lo) r = r - 8'd1;
    return r;
  endfunction

  // One unit toward the target
  function automatic logic [7:0] step_axis(logic [7:0] a, logic [7:0] t);
    logic [7:0] r;
    r = a;
    if (a < t)      r = a + 8'd1;
    else if (a > t) r = a - 8'd1;
    return r;
  endfunction

  // Speed adjust at a segment start; a value above the ceiling is kept on raise
  function automatic logic [7:0] seg_speed(logic [7:0] spd, logic [5:0] stp,
                                           logic up, logic dn);
    logic [8:0] s;
    logic [8:0] n;
    s = {1'b0, spd};
    n = s + {3'b000, stp};
    if (up) begin
      if (n > SPEED_CEIL) n = (s > SPEED_CEIL) ? s : SPEED_CEIL;
      s = n;
    end
    if (dn) s = (s < {3'b000, stp}) ? 9'd0 : s - {3'b000, stp};
    return s[7:0];
  endfunction

endpackage

// ----- sv/teach_and_replay_point_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// teach_and_replay_point_sequencer_unit
// Three-axis servo teach pendant: jogs and records points in teach mode and
// steps the angles through the recorded points in replay mode.
// ----------------------------------------------------------------------------
// Each input beat is one timer tick of pendant button levels and yields one
// result beat. A tick is taken every clock cycle: all per-tick work is done in
// one pass into the state and output registers, and the only stall comes from
// the output register when the result side holds back tready. The point store
// is a MAX_POINTS x 24 memory with a registered read port; the entry after the
// current target is prefetched each cycle, and points 0 and 1 are mirrored in
// flops so that replay can start in the first tick after teach mode. The
// store needs no clearing pass; only recorded entries are ever read. Writes to
// the home registers change the angles shown while replay idles at home; the
// jog start angles and the initial speed load only at reset, which restores
// their defaults.
module teach_and_replay_point_sequencer_unit #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  // Tick beats in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] teach_mode [1] axis0_up [2] axis0_down [3] axis1_up [4] axis1_down
  // [5] axis2_up [6] axis2_down [7] save_button
  input  logic [7:0]  s_axis_tdata,
  // Result beats out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] angle_0 [15:8] angle_1 [23:16] angle_2 [25:24] mode_status
  // [31:26] point_index [38:32] points_stored [39] store_full [47:40] tick_speed
  output logic [47:0] m_axis_tdata
);

  localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0] TWO_CNT = CNT_W'(2);

  // Index of the point after i, wrapping to point 0
  function automatic logic [IDX_W-1:0] next_idx(logic [IDX_W-1:0] i,
                                               logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] n;
    n = CNT_W'(i) + CNT_W'(1);
    return (n >= c) ? '0 : n[IDX_W-1:0];
  endfunction

  // Configuration registers
  logic [7:0]         min_q, max_q;
  tarps_pkg::angles_t home_q;
  logic [5:0]         step_q;

  // Sequencer state
  tarps_pkg::angles_t jog_q, jog_d;
  tarps_pkg::angles_t play_q, play_d;
  tarps_pkg::angles_t tgt_q, tgt_d;
  tarps_pkg::angles_t p0_q, p0_d, p1_q, p1_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [7:0]         wait_q, wait_d;
  logic [7:0]         speed_q, speed_d;
  logic               save_prev_q, save_prev_d;
  logic               dwell_q, dwell_d;
  logic               was_teach_q, was_teach_d;

  // Point store
  tarps_pkg::angles_t mem_q [MAX_POINTS];
  tarps_pkg::angles_t rdata_q;
  logic [IDX_W-1:0]   raddr;
  logic               wr_en;

  // Output register
  logic               m_tvalid_q;
  logic [47:0]        m_tdata_q, m_tdata_d;

  // Tick decode
  logic               accept;
  logic               in_teach, save_btn, save_edge, full;
  logic [5:0]         btn;
  logic [8:0]         wait_inc;
  logic [1:0]         status;
  tarps_pkg::angles_t shown, stepped;
  logic [IDX_W+tarps_pkg::PIDX_W-1:0] idx_ext;
  logic [CNT_W+tarps_pkg::PCNT_W-1:0] cnt_ext;

  assign s_axis_tready = !m_tvalid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_teach      = s_axis_tdata[0];
  assign btn           = s_axis_tdata[6:1];
  assign save_btn      = s_axis_tdata[7];
  assign save_edge     = save_btn && !save_prev_q;
  assign wait_inc      = {1'b0, wait_q} + 9'd1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= tarps_pkg::RST_MIN_ANGLE;
      max_q  <= tarps_pkg::RST_MAX_ANGLE;
      home_q <= {tarps_pkg::RST_HOME_ANGLE_2, tarps_pkg::RST_HOME_ANGLE_1,
                 tarps_pkg::RST_HOME_ANGLE_0};
      step_q <= tarps_pkg::RST_SPEED_STEP;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        tarps_pkg::CFG_MIN_ANGLE:     min_q     <= cfg_wdata_i;
        tarps_pkg::CFG_MAX_ANGLE:     max_q     <= cfg_wdata_i;
        tarps_pkg::CFG_HOME_ANGLE_0:  home_q[0] <= cfg_wdata_i;
        tarps_pkg::CFG_HOME_ANGLE_1:  home_q[1] <= cfg_wdata_i;
        tarps_pkg::CFG_HOME_ANGLE_2:  home_q[2] <= cfg_wdata_i;
        // only read at reset, where the default comes back
        tarps_pkg::CFG_INITIAL_SPEED: ;
        tarps_pkg::CFG_SPEED_STEP:    step_q    <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  // One tick
  always_comb begin
    jog_d       = jog_q;
    play_d      = play_q;
    tgt_d       = tgt_q;
    p0_d        = p0_q;
    p1_d        = p1_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    wait_d      = wait_q;
    speed_d     = speed_q;
    save_prev_d = save_prev_q;
    dwell_d     = dwell_q;
    was_teach_d = was_teach_q;
    wr_en       = 1'b0;
    full        = 1'b0;
    status      = tarps_pkg::MODE_TEACH;
    shown       = jog_q;
    for (int i = 0; i < 3; i++) begin
      stepped[i] = tarps_pkg::step_axis(play_q[i], tgt_q[i]);
    end

    if (accept) begin
      save_prev_d = save_btn;
      if (in_teach) begin
        // jog, then record on the save press
        was_teach_d = 1'b1;
        for (int i = 0; i < 3; i++) begin
          jog_d[i] = tarps_pkg::jog_axis(jog_q[i], btn[2*i], btn[2*i+1], min_q, max_q);
        end
        if (save_edge) begin
          if (cnt_q < MAX_CNT) begin
            wr_en = 1'b1;
            cnt_d = cnt_q + CNT_W'(1);
            if (cnt_q == '0)          p0_d = jog_d;
            if (cnt_q == CNT_W'(1))   p1_d = jog_d;
          end else begin
            full = 1'b1;
          end
        end
        shown  = jog_d;
        status = tarps_pkg::MODE_TEACH;
      end else if (cnt_q < TWO_CNT) begin
        // too few points: show home
        was_teach_d = 1'b0;
        shown       = home_q;
        status      = tarps_pkg::MODE_IDLE;
      end else begin
        if (was_teach_q) begin
          // replay entry: start at point 0 heading for point 1
          was_teach_d = 1'b0;
          play_d      = p0_q;
          tgt_d       = p1_q;
          idx_d       = IDX_W'(1);
          wait_d      = '0;
          speed_d     = tarps_pkg::seg_speed(speed_q, step_q, btn[0], btn[1]);
          dwell_d     = (p0_q == p1_q);
        end else if (wait_inc >= {1'b0, speed_q}) begin
          wait_d = '0;
          if (!dwell_q) begin
            play_d  = stepped;
            dwell_d = (stepped == tgt_q);
          end else begin
            // next segment; its point is the prefetched entry
            idx_d   = next_idx(idx_q, cnt_q);
            tgt_d   = rdata_q;
            speed_d = tarps_pkg::seg_speed(speed_q, step_q, btn[0], btn[1]);
            dwell_d = (play_q == rdata_q);
          end
        end else begin
          wait_d = wait_inc[7:0];
        end
        shown  = play_d;
        status = tarps_pkg::MODE_REPLAY;
      end
    end
  end

  // Prefetch the point after the target the tick leaves behind
  assign raddr = next_idx(idx_d, cnt_q);

  // Result packing, index and count cut to their output widths
  always_comb begin
    idx_ext   = {{tarps_pkg::PIDX_W{1'b0}}, idx_d};
    cnt_ext   = {{tarps_pkg::PCNT_W{1'b0}}, cnt_d};
    m_tdata_d = {speed_d, full, cnt_ext[tarps_pkg::PCNT_W-1:0],
                 idx_ext[tarps_pkg::PIDX_W-1:0], status, shown};
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jog_q       <= {tarps_pkg::RST_HOME_ANGLE_2, tarps_pkg::RST_HOME_ANGLE_1,
                      tarps_pkg::RST_HOME_ANGLE_0};
      play_q      <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      wait_q      <= '0;
      speed_q     <= tarps_pkg::RST_INITIAL_SPEED;
      save_prev_q <= 1'b0;
      dwell_q     <= 1'b0;
      was_teach_q <= 1'b1;
    end else begin
      jog_q       <= jog_d;
      play_q      <= play_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      wait_q      <= wait_d;
      speed_q     <= speed_d;
      save_prev_q <= save_prev_d;
      dwell_q     <= dwell_d;
      was_teach_q <= was_teach_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tgt_q <= tgt_d;
    p0_q  <= p0_d;
    p1_q  <= p1_d;
  end

  // Point store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[cnt_q[IDX_W-1:0]] <= jog_d;
    rdata_q <= mem_q[raddr];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (accept) begin
      m_tvalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) m_tdata_q <= m_tdata_d;
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  // Checks
`include "teach_and_replay_point_sequencer_unit_assert.svh"

  `TARPS_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= MAX_CNT, "point count above store depth")
  `TARPS_ASSERT_IMPL(a_idx_in_range, !was_teach_q && cnt_q >= TWO_CNT, CNT_W'(idx_q) < cnt_q,
                     "replay index beyond stored points")
  `TARPS_ASSERT_NEXT(a_save_counts, accept && in_teach && save_edge && cnt_q < MAX_CNT,
                     cnt_q == $past(cnt_q) + CNT_W'(1), "recorded point not counted")
  `TARPS_ASSERT_IMPL(a_full_flag, m_tvalid_q && m_tdata_q[39], cnt_q == MAX_CNT,
                     "store full flagged below depth")

endmodule

// ----- sim/teach_and_replay_point_sequencer_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for teach_and_replay_point_sequencer_unit
// Drives pendant tick beats through the stream input and checks every result
// beat against a pose predictor. The predictor tracks jog angles, the point
// store and the replay timer. The run opens with a short directed sequence.
// Random phases follow, each with a new register setting: taught points,
// replay runs, speed sweeps and noise. Random idling is applied on both
// sides, and the final phase runs without idling.
// ----------------------------------------------------------------------------
module teach_and_replay_point_sequencer_unit_test;

  localparam int unsigned POINT_CAP   = 64;
  localparam int unsigned QUIET_LIMIT = 1000;

  // Input beat bits
  localparam logic [7:0] B_NONE  = 8'h00;
  localparam logic [7:0] B_TEACH = 8'h01;
  localparam logic [7:0] B_A0UP  = 8'h02;
  localparam logic [7:0] B_A0DN  = 8'h04;
  localparam logic [7:0] B_A1UP  = 8'h08;
  localparam logic [7:0] B_A1DN  = 8'h10;
  localparam logic [7:0] B_A2UP  = 8'h20;
  localparam logic [7:0] B_A2DN  = 8'h40;
  localparam logic [7:0] B_SAVE  = 8'h80;
  localparam logic [7:0] B_JOGS  = 8'h7E;

  // One expected result beat
  typedef struct {
    tarps_pkg::angles_t ang;
    logic [1:0]         mode;
    logic [5:0]         pidx;
    logic [6:0]         pcnt;
    logic               full;
    logic [7:0]         speed;
  } pose_t;

  // Pose predictor and result checker
  class point_sequencer_scoreboard;
    logic [7:0]         lo_limit, hi_limit, start_speed;
    logic [5:0]         speed_step;
    tarps_pkg::angles_t home;
    tarps_pkg::angles_t taught[POINT_CAP];
    tarps_pkg::angles_t jog_pos, play_pos;
    int unsigned        n_taught, target, wait_ticks, speed;
    bit                 save_last, dwelling, from_teach;
    pose_t              expected_poses[$];
    int unsigned        errors;

    function new();
      lo_limit    = tarps_pkg::RST_MIN_ANGLE;
      hi_limit    = tarps_pkg::RST_MAX_ANGLE;
      home[0]     = tarps_pkg::RST_HOME_ANGLE_0;
      home[1]     = tarps_pkg::RST_HOME_ANGLE_1;
      home[2]     = tarps_pkg::RST_HOME_ANGLE_2;
      start_speed = tarps_pkg::RST_INITIAL_SPEED;
      speed_step  = tarps_pkg::RST_SPEED_STEP;
      jog_pos     = home;
      play_pos    = '0;
      n_taught    = 0;
      target      = 0;
      wait_ticks  = 0;
      speed       = tarps_pkg::RST_INITIAL_SPEED;
      save_last   = 1'b0;
      dwelling    = 1'b0;
      from_teach  = 1'b1;
      errors      = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] v);
      case (idx)
        tarps_pkg::CFG_MIN_ANGLE:     lo_limit = v;
        tarps_pkg::CFG_MAX_ANGLE:     hi_limit = v;
        tarps_pkg::CFG_HOME_ANGLE_0:  home[0] = v;
        tarps_pkg::CFG_HOME_ANGLE_1:  home[1] = v;
        tarps_pkg::CFG_HOME_ANGLE_2:  home[2] = v;
        tarps_pkg::CFG_INITIAL_SPEED: start_speed = v;
        tarps_pkg::CFG_SPEED_STEP:    speed_step = v[5:0];
        default: ;
      endcase
    endfunction

    function int unsigned target_slot();
      return (target < n_taught) ? target : 0;
    endfunction

    // Speed buttons apply only here; arriving already on target means dwell
    function void begin_segment(bit slower, bit faster);
      int unsigned s, n;
      s = speed;
      if (slower) begin
        n = s + speed_step;
        if (n > 250) n = (s > 250) ? s : 250;
        s = n;
      end
      if (faster) s = (s < speed_step) ? 0 : s - speed_step;
      speed = s;
      dwelling = (play_pos == taught[target_slot()]);
    endfunction

    function void note_tick(logic [7:0] d);
      pose_t              p;
      bit                 press;
      logic [7:0]         a;
      tarps_pkg::angles_t goal;
      press     = d[7] && !save_last;
      save_last = d[7];
      p.full    = 1'b0;
      if (d[0]) begin
        // Teach: jog up then down within limits, record on press
        from_teach = 1'b1;
        for (int i = 0; i < 3; i++) begin
          a = jog_pos[i];
          if (d[1 + 2 * i] && a < hi_limit) a = a + 8'd1;
          if (d[2 + 2 * i] && a > lo_limit) a = a - 8'd1;
          jog_pos[i] = a;
        end
        if (press) begin
          if (n_taught < POINT_CAP) begin
            taught[n_taught] = jog_pos;
            n_taught++;
          end else begin
            p.full = 1'b1;
          end
        end
        p.ang  = jog_pos;
        p.mode = tarps_pkg::MODE_TEACH;
      end else if (n_taught < 2) begin
        from_teach = 1'b0;
        p.ang  = home;
        p.mode = tarps_pkg::MODE_IDLE;
      end else begin
        // Replay: entry, timer, step or dwell
        if (from_teach) begin
          from_teach = 1'b0;
          play_pos   = taught[0];
          target     = 1;
          wait_ticks = 0;
          begin_segment(d[1], d[2]);
        end else if (wait_ticks + 1 >= speed) begin
          wait_ticks = 0;
          if (!dwelling) begin
            goal = taught[target_slot()];
            for (int i = 0; i < 3; i++) begin
              if (play_pos[i] < goal[i]) play_pos[i] = play_pos[i] + 8'd1;
              else if (play_pos[i] > goal[i]) play_pos[i] = play_pos[i] - 8'd1;
            end
            dwelling = (play_pos == goal);
          end else begin
            target = (target + 1 >= n_taught) ? 0 : target + 1;
            begin_segment(d[1], d[2]);
          end
        end else begin
          wait_ticks++;
        end
        p.ang  = play_pos;
        p.mode = tarps_pkg::MODE_REPLAY;
      end
      p.pidx  = 6'(target);
      p.pcnt  = 7'(n_taught);
      p.speed = 8'(speed);
      expected_poses.push_back(p);
    endfunction

    function void cmp_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_pose(logic [47:0] d);
      pose_t              want;
      tarps_pkg::angles_t got_ang;
      if (expected_poses.size() == 0) begin
        $error("result beat with no tick awaiting it: %h", d);
        errors++;
        return;
      end
      want    = expected_poses.pop_front();
      got_ang = d[23:0];
      for (int i = 0; i < 3; i++)
        cmp_field($sformatf("angle_%0d", i), want.ang[i], got_ang[i]);
      cmp_field("mode_status", want.mode, d[25:24]);
      cmp_field("point_index", want.pidx, d[31:26]);
      cmp_field("points_stored", want.pcnt, d[38:32]);
      cmp_field("store_full", want.full, d[39]);
      cmp_field("tick_speed", want.speed, d[47:40]);
    endfunction

    function int unsigned pending();
      return expected_poses.size();
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_addr_i    = '0;
  logic [7:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [0] teach_mode [1] axis0_up [2] axis0_down [3] axis1_up [4] axis1_down
  // [5] axis2_up [6] axis2_down [7] save_button
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] angle_0 [15:8] angle_1 [23:16] angle_2 [25:24] mode_status
  // [31:26] point_index [38:32] points_stored [39] store_full [47:40] tick_speed
  logic [47:0] m_axis_tdata;

  point_sequencer_scoreboard sb;
  bit          idling_on   = 1'b1;
  int unsigned quiet_cycles = 0;
  int unsigned ticks_sent   = 0;

  teach_and_replay_point_sequencer_unit #(
    .MAX_POINTS(POINT_CAP)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Sample handshakes and register writes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.set_reg(cfg_addr_i, cfg_wdata_i);
      if (s_axis_tvalid && s_axis_tready) sb.note_tick(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_pose(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: ready runs and stall bursts, always ready once idling is off
  initial begin
    int unsigned hold_left;
    bit          ready_now;
    hold_left = 0;
    ready_now = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0) begin
        if (idling_on && $urandom_range(0, 2) == 0) begin
          ready_now = 1'b0;
          hold_left = $urandom_range(1, 18);
        end else begin
          ready_now = 1'b1;
          hold_left = $urandom_range(1, 40);
        end
      end
      m_axis_tready = idling_on ? ready_now : 1'b1;
      hold_left--;
    end
  end

  // Watchdog on cycles with no beat moving
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("FAIL teach_and_replay_point_sequencer_unit");
    $finish;
  end

  function automatic logic [7:0] tick_byte(bit teach, logic [5:0] jogs, bit save);
    return {save, jogs, teach};
  endfunction

  function automatic logic [5:0] sparse_bits();
    return 6'($urandom & $urandom & $urandom);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [7:0] v);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  task automatic set_regs(logic [7:0] mn, logic [7:0] mx, logic [7:0] h0,
                          logic [7:0] h1, logic [7:0] h2, logic [7:0] spd,
                          logic [7:0] stp);
    write_reg(tarps_pkg::CFG_MIN_ANGLE, mn);
    write_reg(tarps_pkg::CFG_MAX_ANGLE, mx);
    write_reg(tarps_pkg::CFG_HOME_ANGLE_0, h0);
    write_reg(tarps_pkg::CFG_HOME_ANGLE_1, h1);
    write_reg(tarps_pkg::CFG_HOME_ANGLE_2, h2);
    write_reg(tarps_pkg::CFG_INITIAL_SPEED, spd);
    write_reg(tarps_pkg::CFG_SPEED_STEP, stp);
  endtask

  task automatic random_regs();
    logic [7:0] mn, mx, stp;
    if ($urandom_range(0, 5) == 0) begin
      mn = 8'($urandom_range(0, 255));
      mx = 8'($urandom_range(0, 255));
    end else begin
      mn = 8'($urandom_range(0, 120));
      mx = 8'($urandom_range(mn + 10, 255));
    end
    stp = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 50))
                                      : 8'($urandom_range(1, 8));
    set_regs(mn, mx, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)), 8'($urandom_range(0, 250)), stp);
  endtask

  // One tick beat, with an optional gap in front
  task automatic send_tick(logic [7:0] d);
    int unsigned gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 18);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = d;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    ticks_sent++;
  endtask

  // Hold off the sender until every result is in
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Jog in a chosen direction per axis, then press and release save
  task automatic teach_burst();
    logic [5:0]  base;
    int unsigned len;
    base = '0;
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 3))
        1: base[2 * i] = 1'b1;
        2: base[2 * i + 1] = 1'b1;
        3: base[2 * i +: 2] = 2'b11;
        default: ;
      endcase
    end
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
    repeat (len) send_tick(tick_byte(1'b1, base ^ sparse_bits(), 1'b0));
    send_tick(tick_byte(1'b1, sparse_bits(), 1'b1));
    send_tick(tick_byte(1'b1, sparse_bits(), 1'b0));
  endtask

  // Replay ticks, mostly speeding up at segment starts
  task automatic replay_run();
    int unsigned len;
    logic [5:0]  j;
    len = $urandom_range(4, 60);
    repeat (len) begin
      j = 6'($urandom) & 6'b111100;
      j[0] = ($urandom_range(0, 7) == 0);
      j[1] = ($urandom_range(0, 2) == 0);
      send_tick(tick_byte(1'b0, j, $urandom_range(0, 3) == 0));
    end
  endtask

  // Alternate teach and replay entry so each entry adjusts the speed
  task automatic speed_sweep();
    bit          slower;
    logic [7:0]  btn;
    slower = ($urandom_range(0, 2) == 0);
    btn = slower ? B_A0UP : B_A0DN;
    repeat ($urandom_range(2, 10)) begin
      send_tick(B_TEACH);
      send_tick(($urandom_range(0, 5) == 0) ? (B_A0UP | B_A0DN) : btn);
    end
  endtask

  task automatic noise_run();
    repeat ($urandom_range(2, 20)) send_tick(8'($urandom));
  endtask

  task automatic run_phase(int unsigned n);
    int unsigned start;
    start = ticks_sent;
    while (ticks_sent - start < n) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7:         teach_burst();
        8, 9, 10, 11, 12, 13, 14, 15:   replay_run();
        16, 17:                         speed_sweep();
        default:                        noise_run();
      endcase
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opening on the reset register values
    send_tick(B_NONE);                              // empty store: idle at home
    send_tick(B_SAVE);                              // save outside teach
    send_tick(B_TEACH | B_SAVE);                    // still held: no press
    send_tick(B_TEACH | B_A0UP | B_A1UP | B_A2UP);
    send_tick(B_TEACH | B_A0DN | B_A1DN | B_A2DN);
    send_tick(B_TEACH | B_A0DN | B_A1DN | B_A2DN);
    send_tick(B_TEACH | B_JOGS);                    // up and down together
    send_tick(B_TEACH);
    send_tick(B_TEACH | B_SAVE);                    // first point
    send_tick(B_NONE);                              // one point: still idle
    send_tick(B_A0UP | B_A0DN);
    send_tick(B_TEACH | B_A1UP);
    send_tick(B_TEACH | B_A1UP | B_A2DN);
    send_tick(B_TEACH | B_A2DN | B_SAVE);           // second point
    send_tick(B_A0UP);                              // replay entry, slower
    send_tick(B_A0DN);                              // mid segment: no effect
    send_tick(8'hFE);
    repeat (3) begin
      send_tick(B_TEACH);
      send_tick(B_A0DN);                            // entry, faster
    end
    repeat (4) send_tick(B_NONE);
    drain();

    // Register extremes, then random settings
    set_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    run_phase(130);
    drain();
    set_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd250, 8'd50);
    run_phase(130);
    repeat (9) begin
      drain();
      random_regs();
      run_phase(130);
    end

    // Last stretch with no idling
    drain();
    random_regs();
    idling_on = 1'b0;
    run_phase(200);
    drain();
    repeat (6) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS teach_and_replay_point_sequencer_unit");
    end else begin
      $display("FAIL teach_and_replay_point_sequencer_unit");
    end
    $finish;
  end

endmodule
